### rtl/core/dfs_maze_carver_macros.svh
// ----------------------------------------------------------------------------
// dfs_maze_carver_macros.svh
// Assertion macros shared by the maze carver RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_MACROS_SVH
`define DFS_MAZE_CARVER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication: when ante holds, cons holds on that edge
`define DMC_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication: when ante holds, cons holds on the following edge
`define DMC_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DMC_ASSERT_IMP(label, ck, rn, ante, cons, msg)
`define DMC_ASSERT_NXT(label, ck, rn, ante, cons, msg)

`endif

`endif

### rtl/core/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, codes and helper functions of the depth-first maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    // configuration port
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]      DIM_RESET       = 7'd64;

    // stream payload
    localparam int RAND_W      = 16;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_COORD_W = 6;
    localparam int OUT_DATA_W  = 16;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_GATHER,
        ST_EVAL,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // wall / move direction codes
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // remainder by three: 4 == 1 mod 3, so base-4 digits can be summed
    function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < RAND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// dfs_maze_carver
// Depth-first (recursive backtracker) maze carver, at most one wall per input beat.
// ----------------------------------------------------------------------------
// One input beat (random word, restart flag) yields exactly one output beat.
// A plain step runs accept, start, the neighbor probes through the single
// read port of the visited bitmap, evaluate, emit. Each cell the block backs
// up through in the visit-order list adds one list read plus a full neighbor
// probe. After reset, and on every beat with begin_new set, the bitmap is
// cleared one entry per cycle, all 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT))
// entries (4096 at default), during which no beat is taken. Configuration
// writes are taken at any time but must only be issued while the block is
// idle. A finished beat may wait at the output while the next input beat is
// already being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_maze_carver_macros.svh"

module dfs_maze_carver #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [dmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [dmc_pkg::CFG_W-1:0]        cfg_wdata,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: [15:0] random_word, [16] begin_new, [23:17] zero
    input  wire logic [dmc_pkg::IN_DATA_W-1:0]    s_tdata,
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: [5:0] wall_x, [11:6] wall_y, [13:12] wall_direction,
    //          [14] wall_valid, [15] maze_done
    output logic      [dmc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import dmc_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = AW + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = (WW > CFG_W) ? WW : CFG_W;
    localparam int DH    = (HW > CFG_W) ? HW : CFG_W;
    localparam int PW    = WW + HW;
    localparam int KW    = (CW > PW) ? CW : PW;
    localparam int BX    = (XW + 1 > WW) ? XW + 1 : WW;
    localparam int BY    = (YW + 1 > HW) ? YW + 1 : HW;

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   grid_width_reg, grid_height_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               restart_pend_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      k_reg;
    logic [XW-1:0]      cur_x_reg;
    logic [YW-1:0]      cur_y_reg;
    logic [2:0]         g_idx_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [RAND_W-1:0]  rw_reg;
    logic [XW-1:0]      gx_reg;
    logic [YW-1:0]      gy_reg;
    logic               inb_reg;
    logic [3:0]         mask_reg;
    logic [OUT_COORD_W-1:0] res_x_reg, res_y_reg;
    logic [1:0]         res_dir_reg;
    logic               res_valid_reg;

    logic [WW-1:0]      dim_w;
    logic [HW-1:0]      dim_h;
    logic [PW-1:0]      cells;
    logic [CW-1:0]      count_eff;
    logic               done_start;
    logic               done_now;
    logic               in_fire;
    logic               begin_new;
    logic               out_free;
    logic               clr_last;

    logic [XW:0]        nb_x;
    logic [YW:0]        nb_y;
    logic               nb_edge_ok;
    logic               nb_inb;
    logic [AW-1:0]      nb_addr;

    logic [2:0]         cand_n;
    logic [1:0]         sel;
    logic [1:0]         pick_dir;
    logic [XW-1:0]      new_x;
    logic [YW-1:0]      new_y;
    logic [AW-1:0]      new_addr;
    logic [AW-1:0]      cur_addr;
    logic [1:0]         prev_dir;
    logic [CW-1:0]      k_dec;

    logic               vis_wr_en;
    logic [AW-1:0]      vis_wr_addr;
    logic               vis_wr_data;
    logic               vis_rd_en;
    logic               vis_rd_data;
    logic               ord_wr_en;
    logic [AW-1:0]      ord_wr_data;
    logic               ord_rd_en;
    logic [AW-1:0]      ord_rd_data;

    // ------------------------------------------------------------------
    // grid size, clamped to 1..MAX
    // ------------------------------------------------------------------
    always_comb
    begin
        if (grid_width_reg == '0)
            dim_w = WW'(1);
        else if (DW'(grid_width_reg) > DW'(MAX_WIDTH))
            dim_w = WW'(MAX_WIDTH);
        else
            dim_w = WW'(grid_width_reg);

        if (grid_height_reg == '0)
            dim_h = HW'(1);
        else if (DH'(grid_height_reg) > DH'(MAX_HEIGHT))
            dim_h = HW'(MAX_HEIGHT);
        else
            dim_h = HW'(grid_height_reg);
    end

    assign cells      = PW'(dim_w) * PW'(dim_h);
    assign count_eff  = (count_reg == '0) ? CW'(1) : count_reg;
    assign done_start = KW'(count_eff) >= KW'(cells);
    assign done_now   = KW'(count_reg) >= KW'(cells);

    assign in_fire   = s_tvalid && s_tready;
    assign begin_new = s_tdata[RAND_W];
    assign out_free  = !out_valid_reg || m_tready;
    assign clr_last  = (clr_addr_reg == {AW{1'b1}});
    assign cur_addr  = {cur_y_reg, cur_x_reg};
    assign prev_dir  = g_idx_reg[1:0] - 2'd1;
    assign k_dec     = k_reg - CW'(1);

    // ------------------------------------------------------------------
    // neighbor probed in the current gather cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        nb_x       = {1'b0, gx_reg};
        nb_y       = {1'b0, gy_reg};
        nb_edge_ok = 1'b1;
        unique case (dir_t'(g_idx_reg[1:0]))
            DIR_RIGHT: nb_x = {1'b0, gx_reg} + (XW+1)'(1);
            DIR_LEFT:
            begin
                nb_edge_ok = (gx_reg != '0);
                nb_x       = {1'b0, gx_reg} - (XW+1)'(1);
            end
            DIR_DOWN:  nb_y = {1'b0, gy_reg} + (YW+1)'(1);
            DIR_UP:
            begin
                nb_edge_ok = (gy_reg != '0);
                nb_y       = {1'b0, gy_reg} - (YW+1)'(1);
            end
        endcase
        nb_inb  = nb_edge_ok && (BX'(nb_x) < BX'(dim_w)) && (BY'(nb_y) < BY'(dim_h));
        nb_addr = {nb_y[YW-1:0], nb_x[XW-1:0]};
    end

    // ------------------------------------------------------------------
    // direction choice: random word modulo candidate count
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [2:0] seen;
        seen     = '0;
        pick_dir = DIR_RIGHT;
        cand_n   = 3'(mask_reg[0]) + 3'(mask_reg[1]) + 3'(mask_reg[2]) + 3'(mask_reg[3]);
        unique case (cand_n)
            3'd2:    sel = {1'b0, rw_reg[0]};
            3'd3:    sel = mod3_16(rw_reg);
            3'd4:    sel = rw_reg[1:0];
            default: sel = 2'd0;
        endcase
        for (int i = 0; i < 4; i++) begin
            if (mask_reg[i])
            begin
                if (seen == {1'b0, sel})
                    pick_dir = 2'(i);
                seen = seen + 3'd1;
            end
        end
    end

    // cell entered by the chosen move
    always_comb
    begin
        new_x = gx_reg;
        new_y = gy_reg;
        unique case (dir_t'(pick_dir))
            DIR_RIGHT: new_x = gx_reg + XW'(1);
            DIR_LEFT:  new_x = gx_reg - XW'(1);
            DIR_DOWN:  new_y = gy_reg + YW'(1);
            DIR_UP:    new_y = gy_reg - YW'(1);
        endcase
        new_addr = {new_y, new_x};
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = restart_pend_reg ? ST_START : ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                    state_next = begin_new ? ST_CLEAR : ST_START;
            ST_START:
                state_next = done_start ? ST_EMIT : ST_GATHER;
            ST_GATHER:
                if (g_idx_reg == 3'd4)
                    state_next = ST_EVAL;
            ST_EVAL:
                if (mask_reg != 4'd0 || k_reg == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_FETCH;
            ST_FETCH:
                state_next = ST_GATHER;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer: handshake and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        vis_wr_en   = 1'b0;
        vis_wr_addr = clr_addr_reg;
        vis_wr_data = 1'b0;
        vis_rd_en   = 1'b0;
        ord_wr_en   = 1'b0;
        ord_wr_data = new_addr;
        ord_rd_en   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
                vis_wr_en = 1'b1;
            ST_START:
                if (count_reg == '0)
                begin
                    // first cell of a fresh maze
                    vis_wr_en   = 1'b1;
                    vis_wr_addr = cur_addr;
                    vis_wr_data = 1'b1;
                    ord_wr_en   = 1'b1;
                    ord_wr_data = cur_addr;
                end
            ST_GATHER:
                vis_rd_en = (g_idx_reg != 3'd4);
            ST_EVAL:
                if (mask_reg != 4'd0)
                begin
                    vis_wr_en   = 1'b1;
                    vis_wr_addr = new_addr;
                    vis_wr_data = 1'b1;
                    ord_wr_en   = 1'b1;
                end
                else
                begin
                    ord_rd_en = (k_reg != '0);
                end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            grid_width_reg   <= DIM_RESET;
            grid_height_reg  <= DIM_RESET;
            clr_addr_reg     <= '0;
            restart_pend_reg <= 1'b0;
            count_reg        <= '0;
            k_reg            <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            g_idx_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_wr_en)
            begin
                if (cfg_addr == CFG_GRID_WIDTH)
                    grid_width_reg <= cfg_wdata;
                else
                    grid_height_reg <= cfg_wdata;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_last)
                        restart_pend_reg <= 1'b0;
                end
                ST_IDLE:
                    if (in_fire && begin_new)
                    begin
                        restart_pend_reg <= 1'b1;
                        count_reg        <= '0;
                        cur_x_reg        <= '0;
                        cur_y_reg        <= '0;
                    end
                ST_START:
                begin
                    count_reg <= count_eff;
                    k_reg     <= count_eff;
                    g_idx_reg <= '0;
                end
                ST_GATHER:
                    g_idx_reg <= g_idx_reg + 3'd1;
                ST_EVAL:
                    if (mask_reg != 4'd0)
                    begin
                        count_reg <= count_reg + CW'(1);
                        cur_x_reg <= new_x;
                        cur_y_reg <= new_y;
                    end
                    else if (k_reg != '0)
                    begin
                        k_reg <= k_dec;
                    end
                ST_FETCH:
                    g_idx_reg <= '0;
                default:
                begin
                end
            endcase

            // output beat register
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rw_reg <= s_tdata[RAND_W-1:0];

        unique case (state_reg)
            ST_START:
            begin
                gx_reg        <= cur_x_reg;
                gy_reg        <= cur_y_reg;
                res_x_reg     <= '0;
                res_y_reg     <= '0;
                res_dir_reg   <= '0;
                res_valid_reg <= 1'b0;
            end
            ST_GATHER:
            begin
                inb_reg <= nb_inb;
                if (g_idx_reg != 3'd0)
                    mask_reg[prev_dir] <= inb_reg && !vis_rd_data;
            end
            ST_EVAL:
                if (mask_reg != 4'd0)
                begin
                    res_x_reg     <= OUT_COORD_W'(gx_reg);
                    res_y_reg     <= OUT_COORD_W'(gy_reg);
                    res_dir_reg   <= pick_dir;
                    res_valid_reg <= 1'b1;
                end
            ST_FETCH:
            begin
                gx_reg <= ord_rd_data[XW-1:0];
                gy_reg <= ord_rd_data[AW-1:XW];
            end
            ST_EMIT:
                if (out_free)
                    out_data_reg <= {done_now, res_valid_reg, res_dir_reg,
                                     res_y_reg, res_x_reg};
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // memories: visited bitmap and visit-order list
    // ------------------------------------------------------------------
    dmc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_visited (
        .clk     (clk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_wr_data),
        .rd_en   (vis_rd_en),
        .rd_addr (nb_addr),
        .rd_data (vis_rd_data)
    );

    dmc_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_order (
        .clk     (clk),
        .wr_en   (ord_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ord_wr_data),
        .rd_en   (ord_rd_en),
        .rd_addr (k_dec[AW-1:0]),
        .rd_data (ord_rd_data)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DMC_ASSERT_IMP(a_pick_in_mask, clk, rst_n, state_reg == ST_EVAL && mask_reg != 4'd0, mask_reg[pick_dir], "chosen direction is not a candidate")
    `DMC_ASSERT_IMP(a_backtrack_bound, clk, rst_n, state_reg == ST_GATHER || state_reg == ST_EVAL, k_reg <= count_reg, "backtrack index beyond visit count")
    `DMC_ASSERT_IMP(a_count_step, clk, rst_n, count_reg != $past(count_reg), count_reg == '0 || count_reg == $past(count_reg) + CW'(1), "visit count jumped")
    `DMC_ASSERT_NXT(a_restart_clears, clk, rst_n, in_fire && begin_new, state_reg == ST_CLEAR && count_reg == '0, "restart did not start a clear pass")

endmodule

`default_nettype wire
